/* hw/rtl/b2d_pkg.sv */
`default_nettype none

package b2d_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned BCD_DIGIT_W = 4;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [BCD_DIGIT_W-1:0] bcd_digit_t;

    localparam char_t CHAR_ZERO  = 8'h30;
    localparam char_t CHAR_MINUS = 8'h2D;

    // Correct one BCD digit before the next doubling: add three at five and above.
    function automatic bcd_digit_t bcd_adjust(input bcd_digit_t d);
        bcd_digit_t r;
        r = (d >= 4'd5) ? bcd_digit_t'(d + 4'd3) : d;
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/b2d_in_if.sv */
`default_nettype none

interface b2d_in_if #(
    parameter int unsigned VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

/* hw/rtl/b2d_out_if.sv */
`default_nettype none

interface b2d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

/* hw/rtl/signed_binary_to_decimal_ascii.sv */
`default_nettype none

// Signed binary to decimal ASCII text.
// Channel number (sink): one two's-complement value of VALUE_BITS bits per transfer.
// Channel text (source): one ASCII character per transfer, '-' first for a
// negative value, then the decimal digits most significant first with no leading
// zeros; zero gives a single '0'. The most negative value prints one minus sign.
// last is high on the final character of each number's text.
// Operation: the number is registered in the idle state, then bit-serial double
// dabble builds the BCD digits, one magnitude bit shifted in per cycle.
// Emission then walks the BCD register one digit per cycle: leading zeros are
// dropped without a transfer; a character waits while the output register is full.
// A negative number emits its sign in a step of its own before the first digit;
// one number is in flight at a time.
// number.ready is high only while the block is idle.
// A stalled receiver holds the output register and the next character waits on it;
// nothing is lost. Reset clears the state machine and the output valid.
module signed_binary_to_decimal_ascii
    import b2d_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    b2d_in_if.sink    number,
    b2d_out_if.source text
);

    // Enough digits for 2^(VALUE_BITS-1); spare high digits stay zero.
    localparam int unsigned DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int unsigned BCD_W  = DIGITS * BCD_DIGIT_W;
    localparam int unsigned BIT_CW = $clog2(VALUE_BITS);
    localparam int unsigned DIG_CW = $clog2(DIGITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [VALUE_BITS-1:0]   mag_reg, mag_next;
    logic [BCD_W-1:0]        bcd_reg, bcd_next;
    logic [BIT_CW-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [DIG_CW-1:0]       dig_cnt_reg, dig_cnt_next;
    logic                    neg_reg, neg_next;
    logic                    started_reg, started_next;
    logic                    out_valid_reg, out_valid_next;
    char_t                   out_char_reg, out_char_next;
    logic                    out_last_reg, out_last_next;

    logic                    out_free;
    logic [BCD_W-1:0]        bcd_adj;
    bcd_digit_t              top_digit;

    assign number.ready   = (state_reg == S_IDLE);
    assign text.valid     = out_valid_reg;
    assign text.character = out_char_reg;
    assign text.last      = out_last_reg;

    // The output register can take a new character when empty or draining.
    assign out_free  = !out_valid_reg || text.ready;
    assign top_digit = bcd_reg[BCD_W-1 -: BCD_DIGIT_W];

    // Adjust every digit before the doubling; digits are independent.
    always_comb
    begin
        for (int i = 0; i < int'(DIGITS); i++)
        begin
            bcd_adj[i*BCD_DIGIT_W +: BCD_DIGIT_W] =
                bcd_adjust(bcd_reg[i*BCD_DIGIT_W +: BCD_DIGIT_W]);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        // Drop the character once the receiver takes it.
        if (out_valid_reg && text.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (number.valid)
                begin
                    neg_next     = number.value[VALUE_BITS-1];
                    // Magnitude fits VALUE_BITS unsigned, so the most negative value is safe.
                    mag_next     = number.value[VALUE_BITS-1]
                                   ? VALUE_BITS'(~number.value + 1'b1)
                                   : VALUE_BITS'(number.value);
                    bcd_next     = '0;
                    bit_cnt_next = BIT_CW'(VALUE_BITS - 1);
                    started_next = 1'b0;
                    state_next   = S_CONV;
                end
            end

            S_CONV:
            begin
                // Double the BCD value and shift in the next magnitude bit.
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
                mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DIG_CW'(DIGITS - 1);
                    state_next   = S_EMIT;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end

            S_EMIT:
            begin
                priority if (!started_reg && top_digit == '0 && dig_cnt_reg != '0)
                begin
                    // Leading zero: advance without a transfer.
                    bcd_next     = {bcd_reg[BCD_W-BCD_DIGIT_W-1:0], {BCD_DIGIT_W{1'b0}}};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else if (out_free && neg_reg)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    neg_next       = 1'b0;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = char_t'(CHAR_ZERO + {4'b0000, top_digit});
                    out_last_next  = (dig_cnt_reg == '0);
                    started_next   = 1'b1;
                    bcd_next       = {bcd_reg[BCD_W-BCD_DIGIT_W-1:0], {BCD_DIGIT_W{1'b0}}};
                    if (dig_cnt_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        dig_cnt_next = dig_cnt_reg - 1'b1;
                    end
                end
                else
                begin
                    // Receiver stalled: hold.
                    state_next = S_EMIT;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mag_reg       <= '0;
            bcd_reg       <= '0;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            neg_reg       <= 1'b0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mag_reg       <= mag_next;
            bcd_reg       <= bcd_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
            neg_reg       <= neg_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
        end
    end

endmodule

`default_nettype wire

/* bench/signed_binary_to_decimal_ascii_tb.sv */
`timescale 1ns / 1ps

// Bench for the signed binary to decimal ASCII converter. Numbers go in on one
// channel, characters come out on the other and are checked in order against a
// text predictor kept in the scoreboard class below.
module signed_binary_to_decimal_ascii_tb;
    import b2d_pkg::*;

    localparam int VALUE_BITS = 32;
    // Watchdog limit, well above what a correct run needs even with the heaviest stalls.
    localparam int CYCLE_LIMIT = 400000;
    // Cycles to hold after the last character, for any stray output.
    localparam int TAIL_CYCLES = 60;
    localparam int RANDOM_PER_PHASE = 22;

    typedef logic signed [VALUE_BITS-1:0] number_t;

    typedef struct packed {
        char_t character;
        logic  last;
    } text_char_t;

    // Scoreboard: turns each accepted number into its expected characters and
    // checks every character transfer against the oldest one waiting.
    class decimal_text_scoreboard;
        text_char_t expected_chars[$];
        int         mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_number(input number_t num);
            logic [VALUE_BITS-1:0] magnitude;
            bcd_digit_t            digits[24];
            int                    ndigits;
            int                    i;
            text_char_t            tc;
            // Unsigned negate: the most negative value keeps its magnitude.
            magnitude = num;
            if (num[VALUE_BITS-1])
                magnitude = ~magnitude + 1'b1;
            ndigits = 0;
            do
            begin
                digits[ndigits] = bcd_digit_t'(magnitude % 10);
                ndigits++;
                magnitude = magnitude / 10;
            end
            while (magnitude != 0);
            if (num[VALUE_BITS-1])
            begin
                tc.character = CHAR_MINUS;
                tc.last      = 1'b0;
                expected_chars.push_back(tc);
            end
            for (i = ndigits - 1; i >= 0; i--)
            begin
                tc.character = char_t'(CHAR_ZERO + digits[i]);
                tc.last      = (i == 0);
                expected_chars.push_back(tc);
            end
        endfunction

        function void check_character(input char_t character, input logic last);
            text_char_t exp_char;
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: unexpected character %h last %b", character, last);
            end
            else
            begin
                exp_char = expected_chars.pop_front();
                if (exp_char.character !== character || exp_char.last !== last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected character %h last %b, got %h last %b",
                                 exp_char.character, exp_char.last, character, last);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    b2d_in_if #(.VALUE_BITS(VALUE_BITS)) number_ch ();
    b2d_out_if                           text_ch ();

    signed_binary_to_decimal_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_ch),
        .text   (text_ch)
    );

    decimal_text_scoreboard text_sb;

    // Idle rates in percent, changed per phase by the stimulus process.
    int send_idle_pct;
    int recv_stall_pct;
    int cycles;

    // Edge cases: zero, single digits, several digit-count boundaries around powers
    // of ten, both extremes of the range and alternating bit patterns.
    number_t directed_numbers[] = '{
        32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
        32'sd99, 32'sd100, -32'sd101, 32'sd999999999, -32'sd999999999,
        32'sd1000000000, 32'sd1234567890, -32'sd1234567890,
        32'sh7FFFFFFF, 32'sh80000000, 32'sh80000001,
        32'sh55555555, 32'shAAAAAAAA, 32'sd5, -32'sd5
    };

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Watchdog: give up on a hung block.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: decide ready at the falling edge, take the character at the rising one.
    always @(negedge clk)
        text_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
        if (rst_n === 1'b1 && text_ch.valid === 1'b1 && text_ch.ready === 1'b1)
            text_sb.check_character(text_ch.character, text_ch.last);

    // Draw a number: fully random, small, of a chosen digit count, or close to
    // a power of ten, with either sign.
    function automatic number_t random_number();
        number_t num;
        longint  lo;
        longint  hi;
        int      shape;
        int      ndigits;
        shape = $urandom_range(3);
        case (shape)
            0: num = $urandom;
            1: num = $urandom_range(999);
            2:
            begin
                ndigits = $urandom_range(10, 1);
                lo = 1;
                repeat (ndigits - 1) lo = lo * 10;
                hi = (ndigits == 10) ? 64'd2147483647 : lo * 10 - 1;
                num = $urandom_range(32'(hi), 32'(lo));
            end
            default:
            begin
                lo = 1;
                repeat ($urandom_range(9)) lo = lo * 10;
                num = number_t'(lo) + $urandom_range(2) - 1;
            end
        endcase
        if (shape != 0 && $urandom_range(1) == 1)
            num = -num;
        return num;
    endfunction

    // Offer one number and hold it until the block takes it.
    task automatic send_number(input number_t num);
        int gap;
        gap = 0;
        if (send_idle_pct > 0)
        begin
            // Mostly short gaps; now and then a long one so the block waits on us.
            if ($urandom_range(9) == 0)
                gap = $urandom_range(60);
            else
                while ($urandom_range(99) < send_idle_pct)
                    gap++;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            number_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        number_ch.valid <= 1'b1;
        number_ch.value <= num;
        do
            @(posedge clk);
        while (number_ch.ready !== 1'b1);
        text_sb.note_number(num);
    endtask

    // Drop valid and hold off until every expected character has come back.
    task automatic drain_text();
        @(negedge clk);
        number_ch.valid <= 1'b0;
        while (text_sb.expected_chars.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int phase;
        text_sb         = new();
        cycles          = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        rst_n           = 1'b0;
        number_ch.valid = 1'b0;
        number_ch.value = '0;
        text_ch.ready   = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // Phases: no idling, slow sender, slow receiver, both mildly idle.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            if (phase == 0)
                foreach (directed_numbers[i])
                    send_number(directed_numbers[i]);
            repeat (RANDOM_PER_PHASE) send_number(random_number());
            // Starve the block between phases so it runs completely dry.
            drain_text();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (text_sb.mismatches == 0 && text_sb.expected_chars.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
